### rtl/sfq_pkg.sv
// ----------------------------------------------------------------------------
// sfq_pkg
// Shared types and constants for the searchable FIFO queue.
// ----------------------------------------------------------------------------
package sfq_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // input kind codes
  localparam logic [1:0] KIND_PUSH   = 2'd0;
  localparam logic [1:0] KIND_POP    = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // classified command codes handed from front to back
  localparam logic [1:0] OP_NOP    = 2'd0;
  localparam logic [1:0] OP_PUSH   = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_SEARCH = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic             error;
    logic [CNT_W-1:0] count;
    logic             empty_res;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] value;
  } cmd_t;

  // handshake between front queue and back end
  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } cmd_if_t;

endpackage

### rtl/sfq_front.sv
// ----------------------------------------------------------------------------
// sfq_front
// Accepts input beats, decodes the kind and buffers commands in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sfq_front import sfq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  output cmd_if_t  cmd_if,
  input  logic     cmd_take
);

  cmd_t       fq_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       accept;
  cmd_t       cmd_in;

  assign busy   = (cnt_r == 2'd2);
  assign accept = start && !busy;

  always_comb begin
    cmd_in.value = in_item.value;
    unique case (in_item.kind)
      KIND_PUSH:   cmd_in.op = OP_PUSH;
      KIND_POP:    cmd_in.op = OP_POP;
      KIND_SEARCH: cmd_in.op = OP_SEARCH;
      default:     cmd_in.op = OP_NOP;
    endcase
  end

  always_comb begin
    wr_nxt  = accept   ? !wr_r : wr_r;
    rd_nxt  = cmd_take ? !rd_r : rd_r;
    cnt_nxt = cnt_r + {1'b0, accept} - {1'b0, cmd_take};
  end

  assign cmd_if.vld = (cnt_r != 2'd0);
  assign cmd_if.cmd = fq_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fq_r[wr_r] <= cmd_in;
    end
  end

endmodule

### rtl/sfq_back.sv
// ----------------------------------------------------------------------------
// sfq_back
// Executes queued commands on the entry store: push, pop, and a search
// that scans held entries one per cycle through a registered read.
// ----------------------------------------------------------------------------
module sfq_back import sfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cmd_if_t   cmd_if,
  output logic      cmd_take,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rdata_r;
  logic             mem_we;

  logic             st_r, st_nxt;
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic [31:0]      key_r, key_nxt;
  logic             hit_r, hit_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             res_vld_r, res_vld_nxt;
  out_item_t        res_r, res_nxt;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    st_nxt      = st_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    left_nxt    = left_r;
    key_nxt     = key_r;
    hit_nxt     = hit_r;
    rd_vld_nxt  = 1'b0;
    res_vld_nxt = 1'b0;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    cmd_take    = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (cmd_if.vld) begin
          cmd_take      = 1'b1;
          res_nxt.found = 1'b0;
          res_nxt.error = 1'b0;
          unique case (cmd_if.cmd.op)
            OP_PUSH: begin
              res_vld_nxt = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_nxt.error = 1'b1;
              end else begin
                mem_we  = 1'b1;
                wp_nxt  = next_slot(wp_r);
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_POP: begin
              res_vld_nxt = 1'b1;
              if (cnt_r == '0) begin
                res_nxt.error = 1'b1;
              end else begin
                rp_nxt  = next_slot(rp_r);
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            OP_SEARCH: begin
              if (cnt_r == '0) begin
                res_vld_nxt = 1'b1;
              end else begin
                st_nxt   = ST_SCAN;
                idx_nxt  = rp_r;
                left_nxt = cnt_r;
                key_nxt  = cmd_if.cmd.value;
                hit_nxt  = 1'b0;
              end
            end
            default: res_vld_nxt = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        // each compare checks the read issued in the previous cycle
        if (left_r != '0) begin
          rd_vld_nxt = 1'b1;
          idx_nxt    = next_slot(idx_r);
          left_nxt   = left_r - 1'b1;
        end
        if (rd_vld_r && (rdata_r == key_r)) begin
          hit_nxt = 1'b1;
        end
        if ((left_r == '0) && !rd_vld_r) begin
          st_nxt        = ST_IDLE;
          res_vld_nxt   = 1'b1;
          res_nxt.found = hit_r;
          res_nxt.error = 1'b0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    res_nxt.count     = cnt_nxt;
    res_nxt.empty_res = (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      left_r    <= '0;
      hit_r     <= 1'b0;
      rd_vld_r  <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      left_r    <= left_nxt;
      hit_r     <= hit_nxt;
      rd_vld_r  <= rd_vld_nxt;
      res_vld_r <= res_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= cmd_if.cmd.value;
    end
    rdata_r <= mem[idx_r];
  end

  assign out_valid = res_vld_r;
  assign out_item  = res_r;

endmodule

### rtl/searchable_fifo_queue.sv
// Push, pop, unused kinds and a search of an empty queue give their result after
// passing through the front command queue and the result register; any other search
// scans the held entries of the store one per cycle through its registered read port,
// then registers its result. Throughput: one push or pop per cycle; a search holds the
// back end for its scan. busy rises when the two-entry command queue fills. The result
// strobe lasts one cycle and cannot be stalled. Synchronous active-low reset empties it.
// ----------------------------------------------------------------------------
// searchable_fifo_queue
// FIFO of signed 32-bit values with push, pop and search-for-value commands.
// ----------------------------------------------------------------------------
module searchable_fifo_queue import sfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_if_t cmd_if;
  logic    cmd_take;

  sfq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .cmd_if   (cmd_if),
    .cmd_take (cmd_take)
  );

  sfq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_if    (cmd_if),
    .cmd_take  (cmd_take),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### verif/sfq_checker.sv
// ----------------------------------------------------------------------------
// sfq_checker
// Watches both channels of the searchable FIFO queue. It keeps its own copy of
// the queue contents, predicts the answer to every accepted command beat and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sfq_checker import sfq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  out_item_t out_item,
  output int        fail_count,
  output int        results_owed,
  output int        hit_count,
  output int        full_rejects,
  output int        empty_rejects
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [31:0] slots [DEPTH];
  logic [PTR_W-1:0]   head_slot;
  logic [PTR_W-1:0]   tail_slot;
  logic [CNT_W-1:0]   fill;
  out_item_t          pending_answers [$];
  out_item_t          want;
  int                 mismatches;
  int                 hits;
  int                 full_drops;
  int                 empty_drops;

  function automatic logic [PTR_W-1:0] bump_slot(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one command to the local copy of the queue and returns its answer.
  function automatic out_item_t predict_answer(input in_item_t beat);
    out_item_t        ans;
    logic [PTR_W-1:0] p;
    ans = '0;
    case (beat.kind)
      KIND_PUSH: begin
        if (fill == CNT_W'(DEPTH)) begin
          ans.error = 1'b1;
        end else begin
          slots[tail_slot] = beat.value;
          tail_slot = bump_slot(tail_slot);
          fill = fill + 1'b1;
        end
      end
      KIND_POP: begin
        if (fill == '0) begin
          ans.error = 1'b1;
        end else begin
          head_slot = bump_slot(head_slot);
          fill = fill - 1'b1;
        end
      end
      KIND_SEARCH: begin
        // only entries currently held take part, oldest first
        p = head_slot;
        for (int i = 0; i < int'(fill); i++) begin
          if (slots[p] == beat.value) ans.found = 1'b1;
          p = bump_slot(p);
        end
      end
      default: ;
    endcase
    ans.count     = fill;
    ans.empty_res = (fill == '0);
    return ans;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned got_v);
    if (exp_v != got_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      head_slot = '0;
      tail_slot = '0;
      fill      = '0;
      pending_answers.delete();
    end else begin
      // a result never belongs to a beat accepted at the same edge
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          $error("result beat with nothing expected: found %0b error %0b count %0d empty %0b",
                 out_item.found, out_item.error, out_item.count, out_item.empty_res);
          mismatches++;
        end else begin
          want = pending_answers.pop_front();
          check_field("found", want.found, out_item.found);
          check_field("error", want.error, out_item.error);
          check_field("count", want.count, out_item.count);
          check_field("empty_res", want.empty_res, out_item.empty_res);
          if (want.found) hits++;
          if (want.error && want.count == '0) empty_drops++;
          if (want.error && want.count != '0) full_drops++;
        end
      end
      if (start && !busy) pending_answers.push_back(predict_answer(in_item));
    end
    fail_count    <= mismatches;
    results_owed  <= pending_answers.size();
    hit_count     <= hits;
    full_rejects  <= full_drops;
    empty_rejects <= empty_drops;
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop and search commands into the searchable FIFO queue: a short
// directed sequence over empty, last-entry and full cases, then random traffic
// that swings between filling and draining. Checking is done by sfq_checker.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfq_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int PHASE_ITEMS  = 470;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  int fail_count;
  int results_owed;
  int hit_count;
  int full_rejects;
  int empty_rejects;
  int stall_cycles;
  int idle_pct;
  int kind_sent [4];
  logic signed [31:0] recent_vals [$];

  searchable_fifo_queue i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  sfq_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_item      (in_item),
    .out_valid    (out_valid),
    .out_item     (out_item),
    .fail_count   (fail_count),
    .results_owed (results_owed),
    .hit_count    (hit_count),
    .full_rejects (full_rejects),
    .empty_rejects(empty_rejects)
  );

  always begin
    #6ns clk = 1'b1;
    #6ns clk = 1'b0;
  end

  // nothing accepted on either side for too long means a hang
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("searchable_fifo_queue verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mix of fully random values, a small pool that gives duplicates, the
  // extremes, and values pushed recently so searches hit.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return 32'(int'($urandom_range(6)) - 3);
      5:          return ($urandom_range(1) == 0) ? VAL_MIN : VAL_MAX;
      default: begin
        if (recent_vals.size() == 0) return $urandom;
        return recent_vals[$urandom_range(recent_vals.size() - 1)];
      end
    endcase
  endfunction

  task automatic send_beat(input logic [1:0] k, input logic signed [31:0] v);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(24, 4) : $urandom_range(3, 1);
      repeat (gap) begin
        @(negedge clk);
        start   <= 1'b0;
        in_item <= '{kind: 2'($urandom), value: $urandom};
      end
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= '{kind: k, value: v};
    do @(posedge clk); while (busy);
    kind_sent[k]++;
    if (k == KIND_PUSH) begin
      recent_vals.push_back(v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (results_owed != 0) @(posedge clk);
  endtask

  // Runs in stretches that lean toward filling, draining or neither, so the
  // queue keeps hitting both full and empty.
  task automatic random_phase(input int pct, input int n_items);
    int         left_in_mode;
    int         push_pct;
    int         pop_pct;
    int         r;
    logic [1:0] k;
    idle_pct     = pct;
    left_in_mode = 0;
    push_pct     = 35;
    pop_pct      = 30;
    for (int i = 0; i < n_items; i++) begin
      if (left_in_mode == 0) begin
        left_in_mode = $urandom_range(40, 8);
        case ($urandom_range(2))
          0:       begin push_pct = 65; pop_pct = 10; end
          1:       begin push_pct = 15; pop_pct = 60; end
          default: begin push_pct = 35; pop_pct = 30; end
        endcase
      end
      left_in_mode--;
      r = $urandom_range(99);
      if (r < 3)                           k = KIND_UNUSED;
      else if (r < 3 + push_pct)           k = KIND_PUSH;
      else if (r < 3 + push_pct + pop_pct) k = KIND_POP;
      else                                 k = KIND_SEARCH;
      send_beat(k, pick_value());
      if ($urandom_range(149) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    idle_pct = 16;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // empty queue: pop underflow, search miss, unused kind ignored
    send_beat(KIND_POP, $urandom);
    send_beat(KIND_SEARCH, 32'sd0);
    send_beat(KIND_UNUSED, -32'sd1);
    // single entry popped, then a search must not see the stale slot
    send_beat(KIND_PUSH, VAL_MIN);
    send_beat(KIND_POP, $urandom);
    send_beat(KIND_SEARCH, VAL_MIN);
    // fill to the brim, then overflow
    send_beat(KIND_PUSH, VAL_MIN);
    send_beat(KIND_PUSH, VAL_MAX);
    send_beat(KIND_PUSH, 32'sd0);
    send_beat(KIND_PUSH, -32'sd1);
    send_beat(KIND_PUSH, 32'sh5555_5555);
    send_beat(KIND_PUSH, 32'shaaaa_aaaa);
    repeat (DEPTH - 6) send_beat(KIND_PUSH, $urandom);
    send_beat(KIND_PUSH, 32'sd42);
    send_beat(KIND_SEARCH, VAL_MAX);
    send_beat(KIND_SEARCH, 32'sd42);
    send_beat(KIND_SEARCH, VAL_MIN);
    send_beat(KIND_POP, $urandom);
    wait_drained();

    random_phase(16, PHASE_ITEMS);
    random_phase(61, PHASE_ITEMS);
    random_phase(0, PHASE_ITEMS);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pushes, %0d pops, %0d searches and %0d unused-kind beats.",
             kind_sent[KIND_PUSH], kind_sent[KIND_POP], kind_sent[KIND_SEARCH],
             kind_sent[KIND_UNUSED]);
    $display("Observed %0d search hits, %0d full-queue drops, %0d empty-queue pops.",
             hit_count, full_rejects, empty_rejects);
    if (fail_count == 0 && results_owed == 0) begin
      $display("searchable_fifo_queue verification clean");
    end else begin
      $display("searchable_fifo_queue verification failed");
    end
    $finish;
  end

endmodule

### searchable_fifo_queue.f
rtl/sfq_pkg.sv
rtl/sfq_front.sv
rtl/sfq_back.sv
rtl/searchable_fifo_queue.sv
verif/sfq_checker.sv
verif/testbench.sv
